// ===== rtl/core/lrukv_pkg.sv =====
`default_nettype none

package lrukv_pkg;

	localparam int DEF_ENTRIES   = 16;
	localparam int DEF_KEY_BITS  = 32;
	localparam int DEF_DATA_BITS = 32;

	// Width of the item fields on the ports and of the capacity input.
	localparam int FIELD_BITS = 32;
	localparam int CAP_BITS   = 5;

	// Capacity after reset, before saturation to the number of entries.
	localparam int CAP_RESET = 16;

	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_PUT = 1'b1;

	localparam logic [FIELD_BITS-1:0] MISS_VALUE = '1;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_RESULT = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/core/lru_key_value_cache.sv =====
// Channel   Handshake                Payload
// in        in_valid / in_ready      func, lookup_key, write_value
// out       out_valid / out_ready    hit, read_value, evicted
// cfg       cfg_valid / cfg_ready    capacity
//
// After an item is accepted, a tag scan reads every entry, one entry a cycle through the
// single read port, then the decision state loads the result. A hit or a put then runs a rank
// update pass over the same memory before the next item is taken; a get miss goes straight
// back to idle.
// Reset clears valid bits and the fill count and loads the reset capacity at once; no clearing pass.
// A new item is taken while the previous result waits; a full result register holds the
// decision cycle, and so the input, until that result is taken.
`default_nettype none

module lru_key_value_cache #(
	parameter int ENTRIES   = lrukv_pkg::DEF_ENTRIES,
	parameter int KEY_BITS  = lrukv_pkg::DEF_KEY_BITS,
	parameter int DATA_BITS = lrukv_pkg::DEF_DATA_BITS
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,

	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic                                  func,
	input  wire logic signed [lrukv_pkg::FIELD_BITS-1:0] lookup_key,
	input  wire logic signed [lrukv_pkg::FIELD_BITS-1:0] write_value,

	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic                                       hit,
	output logic signed [lrukv_pkg::FIELD_BITS-1:0]    read_value,
	output logic                                       evicted,

	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [lrukv_pkg::CAP_BITS-1:0]        capacity
);

	localparam int IDX_BITS  = $clog2(ENTRIES);
	localparam int RANK_BITS = IDX_BITS;
	localparam int CNT_BITS  = $clog2(ENTRIES + 1);
	localparam int CW        = (CNT_BITS > lrukv_pkg::CAP_BITS) ? CNT_BITS
	                                                            : lrukv_pkg::CAP_BITS;
	localparam int CAP_INIT  = (lrukv_pkg::CAP_RESET > ENTRIES) ? ENTRIES
	                                                            : lrukv_pkg::CAP_RESET;

	typedef struct packed {
		logic [KEY_BITS-1:0]  key;
		logic [DATA_BITS-1:0] data;
		logic [RANK_BITS-1:0] rank;
	} entry_t;

	entry_t mem [ENTRIES];
	entry_t mem_rdata_q;
	entry_t wr_word;
	logic   mem_we;

	lrukv_pkg::state_t state_q;

	logic [ENTRIES-1:0]   valid_q;
	logic [CNT_BITS-1:0]  used_q;
	logic [CNT_BITS-1:0]  cap_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 rd_s1;
	logic [IDX_BITS-1:0]  rd_idx_s1;

	logic                 func_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [DATA_BITS-1:0] wdata_q;

	logic                 match_found_q;
	logic [IDX_BITS-1:0]  match_idx_q;
	logic [RANK_BITS-1:0] match_rank_q;
	logic [DATA_BITS-1:0] match_data_q;
	logic                 free_found_q;
	logic [IDX_BITS-1:0]  free_idx_q;
	logic                 lru_found_q;
	logic [IDX_BITS-1:0]  lru_idx_q;
	logic [RANK_BITS-1:0] lru_rank_q;

	logic                 upd_all_q;
	logic                 upd_replace_q;
	logic [IDX_BITS-1:0]  upd_idx_q;
	logic [RANK_BITS-1:0] upd_limit_q;

	logic                                 out_valid_q;
	logic                                 hit_q;
	logic                                 evicted_q;
	logic [lrukv_pkg::FIELD_BITS-1:0]     read_value_q;

	logic                 accept;
	logic                 commit;
	logic                 pass_done;
	logic                 chk_valid;
	logic                 chk_match;
	logic [CW-1:0]        cfg_ext;
	logic [CW-1:0]        cfg_clamped;

	logic                                 dec_update;
	logic                                 dec_fill;
	logic                                 dec_evict;
	logic                                 dec_all;
	logic                                 dec_replace;
	logic [IDX_BITS-1:0]                  dec_idx;
	logic [RANK_BITS-1:0]                 dec_limit;
	logic [lrukv_pkg::FIELD_BITS-1:0]     dec_read;

	assign in_ready  = (state_q == lrukv_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign commit    = (state_q == lrukv_pkg::ST_RESULT) && (!out_valid_q || out_ready);
	assign pass_done = (cnt_q == CNT_BITS'(ENTRIES));

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign evicted    = evicted_q;
	assign read_value = read_value_q;

	assign chk_valid = rd_s1 && valid_q[rd_idx_s1];
	assign chk_match = chk_valid && (mem_rdata_q.key == key_q);

	// Zero means one, and anything above the entry count saturates.
	always_comb begin
		cfg_ext     = CW'(capacity);
		cfg_clamped = cfg_ext;
		if (cfg_ext == '0) begin
			cfg_clamped = CW'(1);
		end else if (cfg_ext > CW'(ENTRIES)) begin
			cfg_clamped = CW'(ENTRIES);
		end
	end

	always_comb begin
		dec_update  = 1'b0;
		dec_fill    = 1'b0;
		dec_evict   = 1'b0;
		dec_all     = 1'b0;
		dec_replace = 1'b0;
		dec_idx     = match_idx_q;
		dec_limit   = match_rank_q;
		dec_read    = '0;
		if (func_q == lrukv_pkg::FUNC_GET) begin
			dec_update = match_found_q;
			dec_read   = match_found_q ? lrukv_pkg::FIELD_BITS'(match_data_q)
			                           : lrukv_pkg::MISS_VALUE;
		end else if (match_found_q) begin
			dec_update = 1'b1;
		end else if ((used_q < cap_q) && free_found_q) begin
			dec_update  = 1'b1;
			dec_fill    = 1'b1;
			dec_all     = 1'b1;
			dec_replace = 1'b1;
			dec_idx     = free_idx_q;
		end else if (lru_found_q) begin
			dec_update  = 1'b1;
			dec_evict   = 1'b1;
			dec_replace = 1'b1;
			dec_idx     = lru_idx_q;
			dec_limit   = lru_rank_q;
		end
	end

	// Write-back word for the entry read in the previous cycle of the update pass.
	always_comb begin
		wr_word = mem_rdata_q;
		mem_we  = 1'b0;
		if ((state_q == lrukv_pkg::ST_UPDATE) && rd_s1) begin
			if (rd_idx_s1 == upd_idx_q) begin
				mem_we       = 1'b1;
				wr_word.rank = '0;
				if (upd_replace_q) begin
					wr_word.key = key_q;
				end
				if (func_q == lrukv_pkg::FUNC_PUT) begin
					wr_word.data = wdata_q;
				end
			end else if (valid_q[rd_idx_s1]) begin
				mem_we = 1'b1;
				if (upd_all_q || (mem_rdata_q.rank < upd_limit_q)) begin
					wr_word.rank = mem_rdata_q.rank + RANK_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[rd_idx_s1] <= wr_word;
		end
		mem_rdata_q <= mem[cnt_q[IDX_BITS-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lrukv_pkg::ST_IDLE;
			cnt_q       <= '0;
			rd_s1       <= 1'b0;
			valid_q     <= '0;
			used_q      <= '0;
			cap_q       <= CNT_BITS'(CAP_INIT);
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= ((state_q == lrukv_pkg::ST_SCAN) || (state_q == lrukv_pkg::ST_UPDATE))
			         && !pass_done;

			if (cfg_valid && cfg_ready && (used_q == '0)) begin
				cap_q <= CNT_BITS'(cfg_clamped);
			end

			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				lrukv_pkg::ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= lrukv_pkg::ST_SCAN;
					end
				end
				lrukv_pkg::ST_SCAN: begin
					if (pass_done) begin
						state_q <= lrukv_pkg::ST_RESULT;
					end else begin
						cnt_q <= cnt_q + CNT_BITS'(1);
					end
				end
				lrukv_pkg::ST_RESULT: begin
					cnt_q <= '0;
					if (commit) begin
						state_q     <= dec_update ? lrukv_pkg::ST_UPDATE : lrukv_pkg::ST_IDLE;
						if (dec_fill) begin
							valid_q[dec_idx] <= 1'b1;
							used_q           <= used_q + CNT_BITS'(1);
						end
					end
				end
				lrukv_pkg::ST_UPDATE: begin
					if (pass_done) begin
						state_q <= lrukv_pkg::ST_IDLE;
					end else begin
						cnt_q <= cnt_q + CNT_BITS'(1);
					end
				end
				default: begin
					state_q <= lrukv_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Item registers, scan trackers, the result register and the update pass controls.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[IDX_BITS-1:0];

		if (accept) begin
			func_q        <= func;
			key_q         <= KEY_BITS'(lookup_key);
			wdata_q       <= DATA_BITS'(write_value);
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			lru_found_q   <= 1'b0;
		end else if (state_q == lrukv_pkg::ST_SCAN) begin
			if (chk_match && !match_found_q) begin
				match_found_q <= 1'b1;
				match_idx_q   <= rd_idx_s1;
				match_rank_q  <= mem_rdata_q.rank;
				match_data_q  <= mem_rdata_q.data;
			end
			if (rd_s1 && !valid_q[rd_idx_s1] && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= rd_idx_s1;
			end
			// The first entry holding the highest rank is the least recent one.
			if (chk_valid && (!lru_found_q || (mem_rdata_q.rank > lru_rank_q))) begin
				lru_found_q <= 1'b1;
				lru_idx_q   <= rd_idx_s1;
				lru_rank_q  <= mem_rdata_q.rank;
			end
		end

		if (commit) begin
			hit_q         <= match_found_q;
			read_value_q  <= dec_read;
			evicted_q     <= dec_evict;
			upd_all_q     <= dec_all;
			upd_replace_q <= dec_replace;
			upd_idx_q     <= dec_idx;
			upd_limit_q   <= dec_limit;
		end
	end

`ifndef SYNTHESIS
	a_used_within_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= cap_q)
		else $error("fill count exceeds capacity");

	a_used_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == used_q)
		else $error("fill count disagrees with valid bits");

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lrukv_pkg::ST_IDLE) |-> !rd_s1)
		else $error("memory read pending while idle");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q)
		else $error("result register not loaded after commit");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

	typedef struct {
		logic                             hit;
		logic [lrukv_pkg::FIELD_BITS-1:0] value;
		logic                             evicted;
	} cache_reply_t;

	// Tracks the cache contents and recency order and predicts each reply.
	class lru_scoreboard;
		bit [lrukv_pkg::CAP_BITS-1:0]     cap_now;
		bit                               slot_live[lrukv_pkg::DEF_ENTRIES];
		logic [lrukv_pkg::FIELD_BITS-1:0] slot_key[lrukv_pkg::DEF_ENTRIES];
		logic [lrukv_pkg::FIELD_BITS-1:0] slot_data[lrukv_pkg::DEF_ENTRIES];
		int unsigned                      slot_age[lrukv_pkg::DEF_ENTRIES];
		int unsigned                      fill;
		cache_reply_t                     replies_due[$];
		int mismatches, checked, gets, puts, hits, evictions, cap_writes, cap_ignored;

		function new();
			cap_now = lrukv_pkg::CAP_BITS'((lrukv_pkg::CAP_RESET > lrukv_pkg::DEF_ENTRIES)
				? lrukv_pkg::DEF_ENTRIES : lrukv_pkg::CAP_RESET);
			fill = 0;
			foreach (slot_live[i]) begin
				slot_live[i] = 1'b0;
				slot_age[i] = 0;
			end
			mismatches = 0;
			checked = 0;
			gets = 0;
			puts = 0;
			hits = 0;
			evictions = 0;
			cap_writes = 0;
			cap_ignored = 0;
		endfunction

		// A capacity write only lands while the cache holds no entries.
		function void set_capacity(bit [lrukv_pkg::CAP_BITS-1:0] v);
			cap_writes++;
			if (fill != 0) begin
				cap_ignored++;
				return;
			end
			if (v == 0)
				cap_now = lrukv_pkg::CAP_BITS'(1);
			else if (v > lrukv_pkg::DEF_ENTRIES)
				cap_now = lrukv_pkg::CAP_BITS'(lrukv_pkg::DEF_ENTRIES);
			else
				cap_now = v;
		endfunction

		// Slot s becomes the newest; live slots newer than limit age by one.
		function void make_newest(int s, int unsigned limit);
			foreach (slot_live[i]) begin
				if (slot_live[i] && i != s && slot_age[i] < limit)
					slot_age[i]++;
			end
			slot_age[s] = 0;
		endfunction

		function void predict_access(logic f, logic [lrukv_pkg::FIELD_BITS-1:0] k,
				logic [lrukv_pkg::FIELD_BITS-1:0] v);
			cache_reply_t r;
			int s;
			int i;
			s = -1;
			for (i = 0; i < lrukv_pkg::DEF_ENTRIES; i++) begin
				if (s < 0 && slot_live[i] && slot_key[i] == k)
					s = i;
			end
			r.hit = (s >= 0);
			r.value = '0;
			r.evicted = 1'b0;
			if (f == lrukv_pkg::FUNC_GET) begin
				gets++;
				if (s >= 0) begin
					r.value = slot_data[s];
					make_newest(s, slot_age[s]);
				end else begin
					r.value = lrukv_pkg::MISS_VALUE;
				end
			end else begin
				puts++;
				if (s >= 0) begin
					slot_data[s] = v;
					make_newest(s, slot_age[s]);
				end else if (fill < cap_now) begin
					for (i = lrukv_pkg::DEF_ENTRIES - 1; i >= 0; i--) begin
						if (!slot_live[i])
							s = i;
					end
					slot_live[s] = 1'b1;
					slot_key[s] = k;
					slot_data[s] = v;
					make_newest(s, 32'hFFFF_FFFF);
					fill++;
				end else begin
					// The oldest live entry is replaced; ties go to the lowest slot.
					for (i = 0; i < lrukv_pkg::DEF_ENTRIES; i++) begin
						if (slot_live[i] && (s < 0 || slot_age[i] > slot_age[s]))
							s = i;
					end
					slot_key[s] = k;
					slot_data[s] = v;
					make_newest(s, slot_age[s]);
					r.evicted = 1'b1;
					evictions++;
				end
			end
			if (r.hit)
				hits++;
			replies_due.push_back(r);
		endfunction

		function void check_reply(logic h, logic [lrukv_pkg::FIELD_BITS-1:0] v, logic e);
			cache_reply_t want;
			checked++;
			if (replies_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"ERROR: reply with no item outstanding: ",
						"hit=%0b value=%h evicted=%0b"}, h, v, e);
				return;
			end
			want = replies_due.pop_front();
			if (h !== want.hit || v !== want.value || e !== want.evicted) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"ERROR: reply %0d: expected hit=%0b value=%h evicted=%0b, ",
						"got hit=%0b value=%h evicted=%0b"},
						checked, want.hit, want.value, want.evicted, h, v, e);
			end
		endfunction

		function int pending_count();
			return replies_due.size();
		endfunction
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	logic                             func = lrukv_pkg::FUNC_GET;
	logic [lrukv_pkg::FIELD_BITS-1:0] lookup_key = '0;
	logic [lrukv_pkg::FIELD_BITS-1:0] write_value = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic                             hit;
	logic [lrukv_pkg::FIELD_BITS-1:0] read_value;
	logic                             evicted;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [lrukv_pkg::CAP_BITS-1:0]   cap_data = '0;

	lru_scoreboard sb = new();
	bit calm = 1'b0;
	logic [lrukv_pkg::FIELD_BITS-1:0] key_pool[lrukv_pkg::DEF_ENTRIES + 4];

	lru_key_value_cache dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.lookup_key  (lookup_key),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.read_value  (read_value),
		.evicted     (evicted),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.capacity    (cap_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	// Reply side: checks every reply and drops ready at random, plus one long hold-off
	// partway through the run so that the block backs up onto its input.
	int hold_left = 0;
	bit hold_done = 1'b0;
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_reply(hit, read_value, evicted);
		if (!hold_done && sb.checked >= 900) begin
			hold_done = 1'b1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < 13) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task write_capacity(input bit [lrukv_pkg::CAP_BITS-1:0] v);
		cfg_valid <= 1'b1;
		cap_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_capacity(v);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task send_item(input logic f, input logic [lrukv_pkg::FIELD_BITS-1:0] k,
			input logic [lrukv_pkg::FIELD_BITS-1:0] v);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < 30)
			gap = $urandom_range(1, 30);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		lookup_key <= k;
		write_value <= v;
		do @(posedge clk); while (!in_ready);
		sb.predict_access(f, k, v);
	endtask

	task wait_for_replies();
		in_valid <= 1'b0;
		while (sb.pending_count() != 0)
			@(posedge clk);
		// The last item may still be updating ranks after its reply has gone out.
		while (!in_ready)
			@(posedge clk);
	endtask

	task fill_key_pool();
		foreach (key_pool[i])
			key_pool[i] = $urandom;
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hFFFF_FFFF;
	endtask

	// Mostly keys from a pool a little larger than the capacity, so hits, fills and
	// evictions all come up; the rest are fresh keys that almost always miss.
	task mixed_traffic(input int count);
		int i;
		int span;
		logic f;
		logic [lrukv_pkg::FIELD_BITS-1:0] k;
		for (i = 0; i < count; i++) begin
			span = sb.cap_now + 4;
			f = ($urandom_range(0, 1) == 1) ? lrukv_pkg::FUNC_PUT : lrukv_pkg::FUNC_GET;
			if ($urandom_range(0, 99) < 85)
				k = key_pool[$urandom_range(0, span - 1)];
			else
				k = $urandom;
			send_item(f, k, $urandom);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fill_key_pool();

		// While empty, every write lands: too large, zero, just above the entry count,
		// then the capacity used for traffic.
		write_capacity(5'd31);
		write_capacity(5'd0);
		write_capacity(5'd17);
		write_capacity(lrukv_pkg::CAP_BITS'($urandom_range(1, lrukv_pkg::DEF_ENTRIES)));

		send_item(lrukv_pkg::FUNC_GET, 32'h8000_0000, 32'h1234_5678);
		send_item(lrukv_pkg::FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_item(lrukv_pkg::FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_item(lrukv_pkg::FUNC_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_item(lrukv_pkg::FUNC_GET, 32'h8000_0000, 32'h0000_0000);
		// A stored all-ones value reads back exactly like a miss, apart from the hit flag.
		send_item(lrukv_pkg::FUNC_GET, 32'h0000_0000, 32'hFFFF_FFFF);
		send_item(lrukv_pkg::FUNC_PUT, 32'h7FFF_FFFF, 32'h0000_0000);
		send_item(lrukv_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
		send_item(lrukv_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h5555_5555);
		send_item(lrukv_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'h5555_5555);
		send_item(lrukv_pkg::FUNC_PUT, 32'h5555_5555, 32'hAAAA_AAAA);
		send_item(lrukv_pkg::FUNC_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
		send_item(lrukv_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		send_item(lrukv_pkg::FUNC_GET, 32'h8000_0000, 32'h0000_0000);
		wait_for_replies();

		calm = 1'b1;
		mixed_traffic(600);
		wait_for_replies();
		calm = 1'b0;

		// The cache holds entries now, so this write must be ignored.
		write_capacity(5'd0);
		mixed_traffic(300);
		wait_for_replies();
		mixed_traffic(300);
		wait_for_replies();

		write_capacity(5'd31);
		fill_key_pool();
		mixed_traffic(1850 - sb.gets - sb.puts);
		wait_for_replies();
		repeat (80) @(posedge clk);

		$display("Ran %0d items (%0d gets, %0d puts) at capacity %0d: %0d hits, %0d evictions.",
			sb.gets + sb.puts, sb.gets, sb.puts, sb.cap_now, sb.hits, sb.evictions);
		$display("Wrote capacity %0d times, %0d of them while the cache held entries.",
			sb.cap_writes, sb.cap_ignored);
		if (sb.mismatches == 0 && sb.pending_count() == 0) begin
			$display("simulation ok");
		end else begin
			$display("Mismatches: %0d, replies still outstanding: %0d",
				sb.mismatches, sb.pending_count());
			$display("simulation failed");
		end
		$finish;
	end

endmodule
